@@ sv/slc_pkg.sv @@
// ----------------------------------------------------------------------------
// slc_pkg
// Shared widths, constants and controller/datapath interface types for the
// sensor line correction core.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 14;
    localparam int CH_W       = 2;
    localparam int LW_W       = 15;
    localparam int PIX_W      = 14;
    localparam int SUM_W      = 28;
    localparam int MAX_WIDTH  = 16384;
    localparam int DIV_BITS   = SUM_W + 2;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS + 1);
    localparam int NUM_CH     = 3;

    localparam logic [LW_W-1:0]     LW_RESET = LW_W'(1024);
    localparam logic [LW_W-1:0]     LW_MAX   = LW_W'(MAX_WIDTH);
    localparam logic [OUT_W-1:0]    OUT_MAX  = 14'h3FFF;
    localparam logic [SAMPLE_W-1:0] U16_MAX  = 16'hFFFF;

    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic load;
        logic mult;
        logic commit;
        logic div_start;
    } slc_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic line_end;
        logic div_busy;
        logic div_done;
    } slc_status_t;

endpackage

@@ sv/slc_div.sv @@
// ----------------------------------------------------------------------------
// slc_div
// Restoring radix-2 divider, one quotient bit per cycle, for the line-end
// smear average.
// ----------------------------------------------------------------------------
module slc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [slc_pkg::DIV_BITS-1:0] dividend,
    input  logic [slc_pkg::LW_W-1:0]   divisor,
    output logic                       busy,
    output logic                       done,
    output logic [slc_pkg::DIV_BITS-1:0] quotient
);
    import slc_pkg::*;

    logic [LW_W-1:0]      rem_reg, rem_next;
    logic [DIV_BITS-1:0]  quo_reg, quo_next;
    logic [LW_W-1:0]      dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [LW_W:0]        trial;
    logic                 fits;

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_BITS-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? LW_W'(trial - {1'b0, dvs_reg}) : trial[LW_W-1:0];
        quo_next = {quo_reg[DIV_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy && (cnt_reg == DIV_CNT_W'(1));
            if (start)
                cnt_reg <= DIV_CNT_W'(DIV_BITS);
            else if (busy)
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

@@ sv/slc_datapath.sv @@
// ----------------------------------------------------------------------------
// slc_datapath
// Dark/smear subtraction, gain multiply, clamp, per-channel line sums and
// smear level update through the shared divider.
// ----------------------------------------------------------------------------
module slc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [slc_pkg::LW_W-1:0]      cfg_wr_data,
    input  logic [slc_pkg::SAMPLE_W-1:0]  raw_sample,
    input  logic [slc_pkg::SAMPLE_W-1:0]  dark_level,
    input  logic [slc_pkg::SAMPLE_W-1:0]  smear_factor,
    input  logic [slc_pkg::SAMPLE_W-1:0]  gain_factor,
    input  logic                          out_stall,
    input  slc_pkg::slc_cmd_t             cmd,
    output slc_pkg::slc_status_t          status,
    output logic                          out_valid,
    output logic [slc_pkg::OUT_W-1:0]     corrected,
    output logic [slc_pkg::CH_W-1:0]      channel,
    output logic                          line_done
);
    import slc_pkg::*;

    logic [LW_W-1:0]     line_width_reg;
    logic [SAMPLE_W-1:0] smear_level_reg [NUM_CH];
    logic [SUM_W-1:0]    line_sum_reg [NUM_CH];
    logic [CH_W-1:0]     channel_count_reg;
    logic [PIX_W-1:0]    pixel_count_reg;

    logic [SAMPLE_W-1:0] diff_reg;
    logic [SAMPLE_W-1:0] smsub_reg;
    logic [SAMPLE_W-1:0] gain_reg;
    logic [SAMPLE_W-1:0] vprod_reg;
    logic [CH_W-1:0]     ch_reg;

    logic                out_valid_reg;
    logic [OUT_W-1:0]    corrected_reg;
    logic [CH_W-1:0]     channel_reg;
    logic                line_done_reg;

    logic [CH_W-1:0]       ch_sel;
    logic [SAMPLE_W-1:0]   smear_sel;
    logic [2*SAMPLE_W-1:0] smear_prod;
    logic [SAMPLE_W-1:0]   sig;
    logic [2*SAMPLE_W-1:0] gain_prod;
    logic [OUT_W-1:0]      v;
    logic [LW_W-1:0]       eff_w;
    logic                  line_end;
    logic                  div_busy, div_done;
    logic [DIV_BITS-1:0]   div_quo;
    logic [SAMPLE_W-1:0]   new_level;

    always_comb
    begin
        ch_sel = (channel_count_reg > CH_BLUE) ? CH_RED : channel_count_reg;
        case (ch_sel)
            CH_GREEN: smear_sel = smear_level_reg[1];
            CH_BLUE:  smear_sel = smear_level_reg[2];
            default:  smear_sel = smear_level_reg[0];
        endcase
        smear_prod = smear_sel * smear_factor;

        sig       = (diff_reg > smsub_reg) ? (diff_reg - smsub_reg) : '0;
        gain_prod = sig * gain_reg;

        v = (vprod_reg[SAMPLE_W-1:OUT_W] != '0) ? OUT_MAX : vprod_reg[OUT_W-1:0];

        if (line_width_reg == '0)
            eff_w = LW_W'(1);
        else if (line_width_reg > LW_MAX)
            eff_w = LW_MAX;
        else
            eff_w = line_width_reg;

        line_end = (ch_reg == CH_BLUE) &&
                   (({1'b0, pixel_count_reg} + LW_W'(1)) >= eff_w);

        new_level = (div_quo[DIV_BITS-1:SAMPLE_W] != '0) ? U16_MAX
                                                         : div_quo[SAMPLE_W-1:0];
    end

    // Division always works on slot 0; slots rotate down after each result,
    // so three passes leave the new levels in order and the sums cleared.
    slc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({line_sum_reg[0], 2'b00}),
        .divisor  (eff_w),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign status.out_busy = out_valid_reg && out_stall;
    assign status.line_end = line_end;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    assign out_valid = out_valid_reg;
    assign corrected = corrected_reg;
    assign channel   = channel_reg;
    assign line_done = line_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg    <= LW_RESET;
            channel_count_reg <= CH_RED;
            pixel_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                smear_level_reg[i] <= '0;
                line_sum_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                line_width_reg <= cfg_wr_data;

            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cmd.commit)
            begin
                case (ch_reg)
                    CH_GREEN: line_sum_reg[1] <= line_sum_reg[1] + SUM_W'(v);
                    CH_BLUE:  line_sum_reg[2] <= line_sum_reg[2] + SUM_W'(v);
                    default:  line_sum_reg[0] <= line_sum_reg[0] + SUM_W'(v);
                endcase
                if (ch_reg == CH_BLUE)
                begin
                    channel_count_reg <= CH_RED;
                    pixel_count_reg   <= line_end ? '0 : pixel_count_reg + PIX_W'(1);
                end
                else
                begin
                    channel_count_reg <= ch_reg + CH_W'(1);
                end
            end
            else if (div_done)
            begin
                line_sum_reg[0]    <= line_sum_reg[1];
                line_sum_reg[1]    <= line_sum_reg[2];
                line_sum_reg[2]    <= '0;
                smear_level_reg[0] <= smear_level_reg[1];
                smear_level_reg[1] <= smear_level_reg[2];
                smear_level_reg[2] <= new_level;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            diff_reg  <= (raw_sample > dark_level) ? (raw_sample - dark_level) : '0;
            smsub_reg <= smear_prod[2*SAMPLE_W-1:SAMPLE_W];
            gain_reg  <= gain_factor;
            ch_reg    <= ch_sel;
        end
        if (cmd.mult)
            vprod_reg <= gain_prod[2*SAMPLE_W-1:SAMPLE_W];
        if (cmd.commit)
        begin
            corrected_reg <= v;
            channel_reg   <= ch_reg;
            line_done_reg <= line_end;
        end
    end

endmodule

@@ sv/slc_ctrl.sv @@
// ----------------------------------------------------------------------------
// slc_ctrl
// Sequencer: sample load, multiply, commit to the output register, and the
// three line-end divisions.
// ----------------------------------------------------------------------------
module slc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  slc_pkg::slc_status_t status,
    output slc_pkg::slc_cmd_t    cmd
);
    import slc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_COMMIT,
        ST_DIV_GO,
        ST_DIV_WAIT
    } state_t;

    state_t          state_reg;
    logic [CH_W-1:0] div_cnt_reg;

    always_comb
    begin
        cmd.load      = (state_reg == ST_IDLE) && in_valid;
        cmd.mult      = (state_reg == ST_MULT);
        cmd.commit    = (state_reg == ST_COMMIT) && !status.out_busy;
        cmd.div_start = (state_reg == ST_DIV_GO);
        in_stall      = (state_reg != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= CH_RED;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_MULT;
                end
                ST_MULT:
                begin
                    state_reg <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (!status.out_busy)
                    begin
                        div_cnt_reg <= CH_RED;
                        state_reg   <= status.line_end ? ST_DIV_GO : ST_IDLE;
                    end
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (status.div_done)
                    begin
                        if (div_cnt_reg == CH_BLUE)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            div_cnt_reg <= div_cnt_reg + CH_W'(1);
                            state_reg   <= ST_DIV_GO;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/sensor_line_correct_core.sv @@
// ----------------------------------------------------------------------------
// sensor_line_correct_core
// Dark, smear and flat-field gain correction of an interleaved R,G,B line.
// ----------------------------------------------------------------------------
// Each sample is loaded with the smear multiply, gain-multiplied and then
// committed to the output register, and the next sample is taken on the cycle
// after commit, even while the previous result still waits. A commit waits
// only if the output register still holds an untaken result. After the blue
// sample that ends a line, the shared one-bit-per-cycle divider computes the
// three smear levels in turn before the first sample of the next line is
// taken. line_width must be written only while the block is idle; the block
// itself does not enforce this.
module sensor_line_correct_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [slc_pkg::LW_W-1:0]      cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [slc_pkg::SAMPLE_W-1:0]  raw_sample,
    input  logic [slc_pkg::SAMPLE_W-1:0]  dark_level,
    input  logic [slc_pkg::SAMPLE_W-1:0]  smear_factor,
    input  logic [slc_pkg::SAMPLE_W-1:0]  gain_factor,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [slc_pkg::OUT_W-1:0]     corrected,
    output logic [slc_pkg::CH_W-1:0]      channel,
    output logic                          line_done
);
    import slc_pkg::*;

    slc_cmd_t    cmd;
    slc_status_t status;

    slc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    slc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .raw_sample   (raw_sample),
        .dark_level   (dark_level),
        .smear_factor (smear_factor),
        .gain_factor  (gain_factor),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .corrected    (corrected),
        .channel      (channel),
        .line_done    (line_done)
    );

    // no new sample while the smear levels are being recomputed
    a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> in_stall)
        else $error("sample accepted during smear division");

    // line end only ever falls on a blue sample
    a_line_done_blue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_done) |-> (channel == CH_BLUE))
        else $error("line end flagged on a non-blue sample");

    // one sample in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transfer accepted while a sample is in flight");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sensor_line_correct_core.
// A queue-fed driver presents colour samples and a clocked monitor takes the
// corrected results. Each accepted transfer is run through a local copy of the
// correction, which keeps its own smear levels, line sums and counters. The
// result is compared field by field, in order. The run covers the line width
// extremes, mid-line width changes and random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

    import slc_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    // let a line-end division run out; leave margin before a width write
    localparam int IDLE_GAP    = 200;
    localparam int HALF_PHASE  = 190;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic [SAMPLE_W-1:0] dark;
        logic [SAMPLE_W-1:0] smear;
        logic [SAMPLE_W-1:0] gain;
    } sample_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic [CH_W-1:0]  ch;
        logic             done;
    } corr_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_wr_en    = 1'b0;
    logic [LW_W-1:0]     cfg_wr_data  = '0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] raw_sample   = '0;
    logic [SAMPLE_W-1:0] dark_level   = '0;
    logic [SAMPLE_W-1:0] smear_factor = '0;
    logic [SAMPLE_W-1:0] gain_factor  = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [OUT_W-1:0]    corrected;
    logic [CH_W-1:0]     channel;
    logic                line_done;

    sample_t sample_q[$];
    corr_t   correction_q[$];
    int      outstanding   = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      fail_cnt      = 0;
    int      cycle_cnt     = 0;

    // local copy of the block state
    logic [LW_W-1:0]     width_reg = LW_RESET;
    logic [SAMPLE_W-1:0] smear_lvl[NUM_CH];
    logic [SUM_W-1:0]    sum_acc[NUM_CH];
    logic [CH_W-1:0]     chan_cnt  = CH_RED;
    logic [PIX_W-1:0]    pix_cnt   = '0;

    initial
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            smear_lvl[c] = '0;
            sum_acc[c]   = '0;
        end
    end

    sensor_line_correct_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .raw_sample   (raw_sample),
        .dark_level   (dark_level),
        .smear_factor (smear_factor),
        .gain_factor  (gain_factor),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .corrected    (corrected),
        .channel      (channel),
        .line_done    (line_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Dark, smear and gain correction of one sample; updates the line state.
    function automatic corr_t correct_sample(input sample_t smp);
        corr_t             r;
        logic [CH_W-1:0]   ch;
        int unsigned       sig;
        int unsigned       w;
        longint unsigned   v;
        longint unsigned   lvl;
        int                c;
        ch  = (chan_cnt > CH_BLUE) ? CH_RED : chan_cnt;
        sig = (smp.raw > smp.dark) ? smp.raw - smp.dark : 0;
        v   = smear_lvl[ch];
        v   = (v * smp.smear) >> 16;
        sig = (sig > v) ? sig - v[31:0] : 0;
        v   = sig;
        v   = (v * smp.gain) >> 16;
        if (v > OUT_MAX)
            v = OUT_MAX;
        sum_acc[ch] = sum_acc[ch] + v[SUM_W-1:0];
        r.done = 1'b0;
        if (ch == CH_BLUE)
        begin
            if (width_reg == 0)
                w = 1;
            else if (width_reg > MAX_WIDTH)
                w = MAX_WIDTH;
            else
                w = width_reg;
            // line ends once the pixel number (index plus one) reaches the width, even past it
            if (pix_cnt + 1 >= w)
            begin
                r.done = 1'b1;
                for (c = 0; c < NUM_CH; c++)
                begin
                    lvl = sum_acc[c];
                    lvl = (lvl * 4) / w;
                    smear_lvl[c] = (lvl > U16_MAX) ? U16_MAX : lvl[SAMPLE_W-1:0];
                    sum_acc[c]   = '0;
                end
                pix_cnt = '0;
            end
            else
                pix_cnt = pix_cnt + 1'b1;
            chan_cnt = CH_RED;
        end
        else
            chan_cnt = ch + 1'b1;
        r.value = v[OUT_W-1:0];
        r.ch    = ch;
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        case ($urandom_range(7))
            0:       s.raw = '0;
            1:       s.raw = '1;
            default: s.raw = SAMPLE_W'($urandom);
        endcase
        case ($urandom_range(7))
            0:       s.dark = '0;
            1:       s.dark = '1;
            2, 3:    s.dark = SAMPLE_W'($urandom);
            default: s.dark = SAMPLE_W'($urandom_range(0, 16'h0FFF));
        endcase
        case ($urandom_range(7))
            0:       s.smear = '0;
            1:       s.smear = '1;
            default: s.smear = SAMPLE_W'($urandom);
        endcase
        // most gains keep the result below the clamp
        case ($urandom_range(7))
            0:       s.gain = '0;
            1:       s.gain = '1;
            2, 3:    s.gain = SAMPLE_W'($urandom);
            default: s.gain = SAMPLE_W'($urandom_range(0, 16'h5000));
        endcase
        return s;
    endfunction

    function automatic logic [LW_W-1:0] pick_width();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return LW_W'($urandom_range(1, 4));
            6, 7:             return LW_W'($urandom_range(5, 40));
            8:                return '0;
            default:          return LW_W'($urandom_range(MAX_WIDTH, (1 << LW_W) - 1));
        endcase
    endfunction

    task automatic queue_sample(input sample_t s);
        sample_q.push_back(s);
        outstanding++;
    endtask

    // every result back, then let a line-end division run out
    task automatic wait_idle();
        while (outstanding != 0)
            @(posedge clk);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic write_width(input logic [LW_W-1:0] w);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        width_reg = w;
    endtask

    // driver: a new sample only once the previous transfer has completed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                correction_q.push_back(correct_sample({raw_sample, dark_level,
                                                       smear_factor, gain_factor}));
            if (!in_valid || !in_stall)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    {raw_sample, dark_level, smear_factor, gain_factor} <=
                        sample_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        corr_t want;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (out_valid && !out_stall)
            begin
                if (correction_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: corrected=%0d channel=%0d line_done=%0b",
                                 corrected, channel, line_done);
                end
                else
                begin
                    want = correction_q.pop_front();
                    outstanding--;
                    if (corrected !== want.value || channel !== want.ch ||
                        line_done !== want.done)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: corrected %0d/%0d channel %0d/%0d line_done %0b/%0b (exp/act)",
                                     want.value, corrected, want.ch, channel,
                                     want.done, line_done);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        int ph;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clamp, dark floor and zero gain at the reset width
        queue_sample('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        queue_sample('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
        queue_sample('{16'h0005, 16'h000A, 16'hFFFF, 16'hFFFF});
        queue_sample('{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF});
        queue_sample('{16'h8000, 16'h0000, 16'h0000, 16'h8000});
        queue_sample('{16'h1234, 16'h0000, 16'hFFFF, 16'h0000});
        wait_idle();
        // width 0 acts as 1 and ends the part-done line; levels reach or near saturation
        write_width('0);
        repeat (3) queue_sample('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
        // full smear at the near-saturated levels
        queue_sample('{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF});
        queue_sample('{16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF});
        queue_sample('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        wait_idle();
        write_width('1);
        repeat (3) queue_sample(random_sample());
        wait_idle();
        write_width(LW_W'(MAX_WIDTH + 1));
        repeat (3) queue_sample(random_sample());
        wait_idle();
        // narrowing mid-line ends the long line at the next blue sample
        write_width(LW_W'(2));
        repeat (6) queue_sample(random_sample());
        wait_idle();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 88; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 88; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            write_width(pick_width());
            repeat (HALF_PHASE) queue_sample(random_sample());
            // sender holds off here until every result is back
            wait_idle();
            write_width(pick_width());
            repeat (HALF_PHASE) queue_sample(random_sample());
            wait_idle();
        end

        if (fail_cnt == 0 && correction_q.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/slc_pkg.sv
sv/slc_div.sv
sv/slc_datapath.sv
sv/slc_ctrl.sv
sv/sensor_line_correct_core.sv
test/tb.sv
